// File: sv/priority_front_deque_defines.svh
// Assertion macros shared by the priority front deque RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the using module.
`ifndef PRIORITY_FRONT_DEQUE_DEFINES_SVH
`define PRIORITY_FRONT_DEQUE_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PFD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("pfd assertion failed");

// Checks that a consequence holds in the cycle after its antecedent.
`define PFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfd assertion failed");

`endif

// File: sv/pfd_pkg.sv
// Package for the priority front deque: sizes, codes and request/result types.
// Used by pfd_store, pfd_ctrl and priority_front_deque.
package pfd_pkg;

  localparam int DEPTH    = 64;
  localparam int TAG_BITS = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                action;
    logic                priority_req;
    logic [TAG_BITS-1:0] entry_tag;
  } req_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] removed_tag;
    logic                removed_valid;
    status_e             status_code;
    logic [CNT_W-1:0]    occupancy;
    logic                not_empty;
  } res_t;

  // Access to the entry store for one request.
  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [TAG_BITS-1:0] wdata;
    logic                re;
    logic [IDX_W-1:0]    raddr;
  } store_req_t;

endpackage

// File: sv/pfd_store.sv
// Entry store of the priority front deque: one write and one registered read per cycle.
// Depends on pfd_pkg.
module pfd_store
  import pfd_pkg::*;
(
  input  logic                clk_i,
  input  store_req_t          store_req_i,
  output logic [TAG_BITS-1:0] rd_data_o
);

  logic [TAG_BITS-1:0] mem_q [DEPTH];
  logic [TAG_BITS-1:0] rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (store_req_i.we) begin
      mem_q[store_req_i.waddr] <= store_req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (store_req_i.re) begin
      rd_q <= mem_q[store_req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: sv/pfd_ctrl.sv
// Control of the priority front deque: request register, front index, count and result register.
// Depends on pfd_pkg and priority_front_deque_defines.svh.
`include "priority_front_deque_defines.svh"

module pfd_ctrl
  import pfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  req_t                request_i,
  input  logic [TAG_BITS-1:0] rd_data_i,
  output store_req_t          store_req_o,
  output logic                done_o,
  output res_t                result_o
);

  req_t             req_q;
  logic             vld_q;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  res_t             res_q, res_d;
  logic             done_q;

  logic             is_insert, is_remove, full, empty;
  logic [IDX_W-1:0] front_dec, front_inc, back_idx;
  logic [CNT_W:0]   back_sum;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q <= request_i;
    end
  end

  // Ring index arithmetic; the back slot wraps with one compare and subtract.
  always_comb begin
    front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
    front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
    back_sum  = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(count_q);
    if (back_sum >= (CNT_W + 1)'(DEPTH)) begin
      back_idx = IDX_W'(back_sum - (CNT_W + 1)'(DEPTH));
    end else begin
      back_idx = IDX_W'(back_sum);
    end
  end

  // Decode of the registered request against the current state.
  always_comb begin
    full      = (count_q == CNT_W'(DEPTH));
    empty     = (count_q == '0);
    is_insert = vld_q && (req_q.action == ACT_INSERT);
    is_remove = vld_q && (req_q.action == ACT_REMOVE);
  end

  // Next state, store access and result fields.
  always_comb begin
    front_d           = front_q;
    count_d           = count_q;
    store_req_o.we    = 1'b0;
    store_req_o.waddr = back_idx;
    store_req_o.wdata = req_q.entry_tag;
    store_req_o.re    = 1'b0;
    store_req_o.raddr = front_q;
    res_d.removed_tag   = '0;
    res_d.removed_valid = 1'b0;
    res_d.status_code   = ST_DONE;
    if (is_insert) begin
      if (full) begin
        res_d.status_code = ST_FULL;
      end else begin
        store_req_o.we = 1'b1;
        count_d        = count_q + 1'b1;
        if (req_q.priority_req) begin
          front_d           = front_dec;
          store_req_o.waddr = front_dec;
        end
      end
    end else if (is_remove) begin
      if (empty) begin
        res_d.status_code = ST_EMPTY;
      end else begin
        store_req_o.re      = 1'b1;
        res_d.removed_valid = 1'b1;
        front_d             = front_inc;
        count_d             = count_q - 1'b1;
      end
    end
    res_d.occupancy = count_d;
    res_d.not_empty = (count_d != '0);
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      done_q  <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  // The removed tag arrives from the store read register in the result cycle.
  always_comb begin
    result_o = res_q;
    result_o.removed_tag = res_q.removed_valid ? rd_data_i : '0;
  end

  assign done_o = done_q;

  `PFD_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH))
  `PFD_ASSERT_NEXT(a_refused_keeps_count, res_d.status_code != ST_DONE, $stable({count_q, front_q}))
  `PFD_ASSERT_NEXT(a_remove_decrements, is_remove && !empty, count_q == $past(count_q) - 1'b1)
  `PFD_ASSERT_NEXT(a_result_follows, vld_q, done_q && (res_q.occupancy == count_q))

endmodule

// File: sv/priority_front_deque.sv
// Top level of the priority front deque: instantiates the control and the entry store.
// Depends on pfd_pkg, pfd_ctrl and pfd_store.
//
// A bounded deque of up to DEPTH tags. A request is taken whenever start is high; busy is
// never raised, so one request can be issued every clock cycle. Each request gives exactly one
// result, strobed by done_o for a single cycle once the request has passed the request register
// and then the result register, which is also where the entry store's read port registers the
// removed tag. The receiver cannot stall results and must take each one in the cycle it is shown.
// Inserts into a full deque and removes from an empty one are refused with a status code and
// leave the contents unchanged.
module priority_front_deque
  import pfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t request_i,
  output logic done_o,
  output res_t result_o
);

  store_req_t          store_req;
  logic [TAG_BITS-1:0] rd_data;
  logic                accept;

  // Every request is processed in a single pass, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  pfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .request_i   (request_i),
    .rd_data_i   (rd_data),
    .store_req_o (store_req),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  pfd_store u_store (
    .clk_i       (clk_i),
    .store_req_i (store_req),
    .rd_data_o   (rd_data)
  );

endmodule

// File: verif/priority_front_deque_tb.sv
// Self-checking testbench for priority_front_deque: directed and random insert/remove requests.
// Depends on pfd_pkg for the request and result types and on the priority_front_deque RTL.
// A mirror of the deque predicts every result, and a monitor compares results in request order.
module priority_front_deque_tb
  import pfd_pkg::*;
();

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t request_i;
  logic done_o;
  res_t result_o;

  // Mirror of the deque contents, used to predict each result.
  logic [TAG_BITS-1:0] mirror_tags [DEPTH];
  int unsigned         mirror_head;
  int unsigned         mirror_count;

  // Results predicted for accepted requests, oldest first.
  res_t pending_results [$];
  res_t oldest_expected;
  int   error_count;

  // Sender pacing: bursts of requests separated by idle gaps.
  int   burst_left;
  bit   gapless;

  priority_front_deque u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .request_i(request_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the mirror and returns the result the block must give.
  function automatic res_t predict_deque_result(req_t req);
    res_t res;
    res = '0;
    res.status_code = ST_DONE;
    if (req.action == ACT_INSERT) begin
      if (mirror_count >= DEPTH) begin
        res.status_code = ST_FULL;
      end else if (req.priority_req) begin
        // A priority entry goes in ahead of the current front.
        mirror_head = (mirror_head == 0) ? DEPTH - 1 : mirror_head - 1;
        mirror_tags[mirror_head] = req.entry_tag;
        mirror_count++;
      end else begin
        mirror_tags[(mirror_head + mirror_count) % DEPTH] = req.entry_tag;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        res.status_code = ST_EMPTY;
      end else begin
        res.removed_tag   = mirror_tags[mirror_head];
        res.removed_valid = 1'b1;
        mirror_head       = (mirror_head + 1) % DEPTH;
        mirror_count--;
      end
    end
    res.occupancy = CNT_W'(mirror_count);
    res.not_empty = (mirror_count != 0);
    return res;
  endfunction

  // Sends one request, called at a rising edge; returns at the edge that accepts it.
  task automatic send_request(logic act, logic prio, logic [TAG_BITS-1:0] tag);
    req_t req;
    req.action       = act;
    req.priority_req = prio;
    req.entry_tag    = tag;
    start     <= 1'b1;
    request_i <= req;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    pending_results.push_back(predict_deque_result(req));
  endtask

  // Inserts an idle gap between bursts unless the current stretch runs back to back.
  task automatic pace_sender();
    int gap;
    if (gapless) return;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Sends one request with random content; insert_pct sets the share of inserts.
  task automatic send_random(int insert_pct);
    logic act;
    act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    send_request(act, 1'($urandom), TAG_BITS'($urandom));
    pace_sender();
  endtask

  // Compares one result field and reports a mismatch.
  function automatic void compare_field(string field, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, expected, actual);
      error_count++;
    end
  endfunction

  // Result monitor: each strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual 0x%0h",
                 $time, result_o);
        error_count++;
      end else begin
        oldest_expected = pending_results.pop_front();
        compare_field("removed_tag", oldest_expected.removed_tag, result_o.removed_tag);
        compare_field("removed_valid", oldest_expected.removed_valid, result_o.removed_valid);
        compare_field("status_code", oldest_expected.status_code, result_o.status_code);
        compare_field("occupancy", oldest_expected.occupancy, result_o.occupancy);
        compare_field("not_empty", oldest_expected.not_empty, result_o.not_empty);
      end
    end
  end

  // Extreme tags, both insert ends, front wrap below slot zero, and removes from empty.
  task automatic test_directed_basics();
    gapless = 1'b1;
    send_request(ACT_REMOVE, 1'b0, '0);
    send_request(ACT_INSERT, 1'b0, 16'h0000);
    send_request(ACT_INSERT, 1'b1, 16'hFFFF);
    send_request(ACT_INSERT, 1'b0, 16'h8001);
    send_request(ACT_INSERT, 1'b1, 16'h7FFE);
    repeat (4) send_request(ACT_REMOVE, 1'b0, 16'hFFFF);
    send_request(ACT_REMOVE, 1'b1, 16'hFFFF);
    send_request(ACT_INSERT, 1'b1, 16'h1234);
    send_request(ACT_INSERT, 1'b0, 16'hEDCB);
    send_request(ACT_REMOVE, 1'b1, 16'h0000);
    send_request(ACT_REMOVE, 1'b0, 16'h0000);
    send_request(ACT_REMOVE, 1'b1, 16'h0000);
    gapless = 1'b0;
  endtask

  // Fills the deque to capacity, checks refused inserts, then drains it past empty.
  task automatic test_fill_and_drain();
    while (mirror_count < DEPTH) begin
      send_request(ACT_INSERT, 1'($urandom), TAG_BITS'($urandom));
      pace_sender();
    end
    send_request(ACT_INSERT, 1'b0, TAG_BITS'($urandom));
    send_request(ACT_INSERT, 1'b1, TAG_BITS'($urandom));
    send_request(ACT_INSERT, 1'($urandom), TAG_BITS'($urandom));
    pace_sender();
    while (mirror_count > 0) begin
      send_request(ACT_REMOVE, 1'($urandom), TAG_BITS'($urandom));
      pace_sender();
    end
    send_request(ACT_REMOVE, 1'b0, TAG_BITS'($urandom));
    send_request(ACT_REMOVE, 1'b1, TAG_BITS'($urandom));
    pace_sender();
  endtask

  // Random traffic in phases that lean toward filling, draining or holding steady.
  task automatic test_random_traffic(int total);
    int sent;
    int phase_len;
    int insert_pct;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 3))
        0: insert_pct = 85;
        1: insert_pct = 15;
        2: insert_pct = 55;
        default: insert_pct = 45;
      endcase
      gapless = ($urandom_range(0, 3) == 0);
      repeat (phase_len) send_random(insert_pct);
      sent += phase_len;
    end
    gapless = 1'b0;
  endtask

  // Run limit well above the slowest correct run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int settle;
    rst_ni       = 1'b0;
    start        = 1'b0;
    request_i    = '0;
    mirror_head  = 0;
    mirror_count = 0;
    error_count  = 0;
    burst_left   = $urandom_range(1, 24);
    gapless      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_fill_and_drain();
    test_random_traffic(1200);

    // Let every outstanding result arrive, then keep watching for stray strobes.
    start <= 1'b0;
    settle = 0;
    while (pending_results.size() != 0 && settle < 1000) begin
      @(posedge clk_i);
      settle++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 waiting, actual %0d",
               $time, pending_results.size(), pending_results.size());
      error_count++;
    end
    repeat (4) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/pfd_pkg.sv
sv/pfd_store.sv
sv/pfd_ctrl.sv
sv/priority_front_deque.sv
verif/priority_front_deque_tb.sv
